FILE: rtl/pbl_pkg.sv
// Shared types, codes and arithmetic helpers for the pixel tone-and-blend pipeline.
`timescale 1ns / 1ps

package pbl_pkg;

  localparam int unsigned StageCount = 5;

  localparam logic [2:0] CFG_GLOBAL_ALPHA = 3'd0;
  localparam logic [2:0] CFG_BLEND_MODE   = 3'd1;
  localparam logic [2:0] CFG_SATURATION   = 3'd2;
  localparam logic [2:0] CFG_TONE_RED     = 3'd3;
  localparam logic [2:0] CFG_TONE_GREEN   = 3'd4;
  localparam logic [2:0] CFG_TONE_BLUE    = 3'd5;

  localparam logic [2:0] MODE_COPY  = 3'd0;
  localparam logic [2:0] MODE_ALPHA = 3'd1;
  localparam logic [2:0] MODE_MASK  = 3'd2;
  localparam logic [2:0] MODE_ADD   = 3'd3;
  localparam logic [2:0] MODE_SUB   = 3'd4;

  localparam logic [14:0] LUMA_R = 15'd6969;
  localparam logic [14:0] LUMA_G = 15'd23434;
  localparam logic [14:0] LUMA_B = 15'd2365;
  localparam int unsigned LumaShift = 15;

  localparam logic [7:0] FULL = 8'd255;

  typedef struct packed {
    logic s0;
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pbl_load_t;

  // exact x / 255 for any x below 65280, where the quotient fits in 8 bits
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

FILE: rtl/pbl_lane.sv
// One colour channel: desaturate, tone, weight and combine with the destination.
`timescale 1ns / 1ps

module pbl_lane
  import pbl_pkg::*;
(
  input  logic              clk,
  input  pbl_load_t         load,
  input  logic [7:0]        src,
  input  logic [7:0]        dst,
  input  logic [7:0]        luma,
  input  logic [7:0]        saturation,
  input  logic signed [8:0] tone,
  input  logic [7:0]        beta,
  input  logic [2:0]        mode,
  input  logic              dst_zero,
  output logic [7:0]        result
);

  logic [7:0]  s0, d0, s1, d1, s2, d2, s3, d3;
  logic [15:0] ps3, pd3;

  logic [7:0]  sat_inv;
  logic [15:0] mix_s, mix_y, mix1;
  logic [8:0]  tone_abs;
  logic [7:0]  tone_mag, tone_inv;
  logic [15:0] tone_t, tone_c, mix2;
  logic [7:0]  beta_inv;
  logic [15:0] prod_s, prod_d;
  logic [7:0]  lerp4, w4;
  logic [8:0]  add_raw, add_w;
  logic [7:0]  res_next;

  assign sat_inv = FULL - saturation;
  assign mix_s   = {8'd0, s0} * {8'd0, saturation};
  assign mix_y   = {8'd0, luma} * {8'd0, sat_inv};
  assign mix1    = mix_s + mix_y;

  assign tone_abs = tone[8] ? (~tone + 9'd1) : tone;
  assign tone_mag = tone_abs[8] ? FULL : tone_abs[7:0];
  assign tone_inv = FULL - tone_mag;
  assign tone_t   = (tone[8] || tone == 9'sd0) ? 16'd0 : {8'd0, FULL} * {8'd0, tone_mag};
  assign tone_c   = {8'd0, s1} * {8'd0, tone_inv};
  assign mix2     = tone_t + tone_c;

  assign beta_inv = FULL - beta;
  assign prod_s   = {8'd0, s2} * {8'd0, beta};
  assign prod_d   = {8'd0, d2} * {8'd0, beta_inv};

  assign lerp4   = div255(ps3 + pd3);
  assign w4      = div255(ps3);
  assign add_raw = {1'b0, d3} + {1'b0, s3};
  assign add_w   = {1'b0, d3} + {1'b0, w4};

  always_comb begin
    res_next = d3;
    case (mode)
      MODE_COPY: res_next = s3;
      MODE_ALPHA: res_next = dst_zero ? s3 : lerp4;
      MODE_ADD: begin
        if (dst_zero) res_next = add_raw[8] ? FULL : add_raw[7:0];
        else          res_next = add_w[8] ? FULL : add_w[7:0];
      end
      MODE_SUB: begin
        if (dst_zero) res_next = (d3 > s3) ? d3 - s3 : 8'd0;
        else          res_next = (d3 > w4) ? d3 - w4 : 8'd0;
      end
      default: res_next = d3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load.s0) begin
      s0 <= src;
      d0 <= dst;
    end
    if (load.s1) begin
      s1 <= div255(mix1);
      d1 <= d0;
    end
    if (load.s2) begin
      s2 <= div255(mix2);
      d2 <= d1;
    end
    if (load.s3) begin
      ps3 <= prod_s;
      pd3 <= prod_d;
      s3  <= s2;
      d3  <= d2;
    end
    if (load.s4) begin
      result <= res_next;
    end
  end

endmodule

FILE: rtl/pixel_tone_and_blend.sv
// Top level of the pixel tone-and-blend pipeline: config registers, control and alpha path.
`timescale 1ns / 1ps
//
// Usage: each input word is a source RGBA8 pixel and the destination RGBA8 pixel
// under it; the output word is the new destination pixel. No state is kept
// between pixels.
// Input channel: in_valid / in_stall, a word is taken when in_valid is high and
// in_stall low. Output channel: out_valid / out_stall, same rule, out_stall
// driven by the receiver.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Registers: 0 global alpha, 1 blend mode, 2 saturation level,
// 3..5 red, green, blue tone. Write them only while the pipeline is empty.
// A word passes five register stages before out_valid rises. Throughput: one pixel
// per clock while out_stall is low, set by the five-stage pipeline of multiplies
// and /255 steps.
// A stalled receiver holds the output register; stages behind it keep filling
// until every stage holds a word, then in_stall rises.
// Reset empties the pipeline and restores the register defaults.
//

module pixel_tone_and_blend
  import pbl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] src_r,
  input  logic [7:0] src_g,
  input  logic [7:0] src_b,
  input  logic [7:0] src_a,
  input  logic [7:0] dst_r,
  input  logic [7:0] dst_g,
  input  logic [7:0] dst_b,
  input  logic [7:0] dst_a,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_r,
  output logic [7:0] out_g,
  output logic [7:0] out_b,
  output logic [7:0] out_a,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data
);

  logic [7:0]        global_alpha, saturation_level;
  logic [2:0]        blend_mode;
  logic signed [8:0] tone_red, tone_green, tone_blue;

  logic [StageCount-1:0] valid;
  pbl_load_t             load;

  logic [7:0]  luma0, sa0, sr0, da0, beta1, sa1, sr1, da1;
  logic [7:0]  beta2, sa2, sr2, da2, beta3, sa3, sr3, da3;
  logic [15:0] pa0, pa_next;
  logic [22:0] luma_sum;
  logic [22:0] luma_pr, luma_pg, luma_pb;
  logic [7:0]  alpha_next;
  logic        dst_zero;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      global_alpha     <= FULL;
      blend_mode       <= MODE_ALPHA;
      saturation_level <= FULL;
      tone_red         <= 9'sd0;
      tone_green       <= 9'sd0;
      tone_blue        <= 9'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GLOBAL_ALPHA: global_alpha     <= cfg_data[7:0];
        CFG_BLEND_MODE:   blend_mode       <= cfg_data[2:0];
        CFG_SATURATION:   saturation_level <= cfg_data[7:0];
        CFG_TONE_RED:     tone_red         <= cfg_data;
        CFG_TONE_GREEN:   tone_green       <= cfg_data;
        CFG_TONE_BLUE:    tone_blue        <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage loads when empty or when the stage after it moves on
  assign load.s4  = !valid[4] || !out_stall;
  assign load.s3  = !valid[3] || load.s4;
  assign load.s2  = !valid[2] || load.s3;
  assign load.s1  = !valid[1] || load.s2;
  assign load.s0  = !valid[0] || load.s1;
  assign in_stall = !load.s0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load.s0) valid[0] <= in_valid;
      if (load.s1) valid[1] <= valid[0];
      if (load.s2) valid[2] <= valid[1];
      if (load.s3) valid[3] <= valid[2];
      if (load.s4) valid[4] <= valid[3];
    end
  end

  assign out_valid = valid[4];

  assign luma_pr  = {8'd0, LUMA_R} * {15'd0, src_r};
  assign luma_pg  = {8'd0, LUMA_G} * {15'd0, src_g};
  assign luma_pb  = {8'd0, LUMA_B} * {15'd0, src_b};
  assign luma_sum = luma_pr + luma_pg + luma_pb;
  assign pa_next  = {8'd0, src_a} * {8'd0, global_alpha};

  assign dst_zero = (da3 == 8'd0);

  always_comb begin
    alpha_next = da3;
    case (blend_mode) inside
      MODE_COPY: alpha_next = sa3;
      MODE_MASK: alpha_next = sr3;
      MODE_ALPHA, MODE_ADD, MODE_SUB: begin
        if (dst_zero || da3 < beta3) alpha_next = beta3;
        else                         alpha_next = da3;
      end
      default: alpha_next = da3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load.s0) begin
      luma0 <= luma_sum[LumaShift +: 8];
      pa0   <= pa_next;
      sa0   <= src_a;
      sr0   <= src_r;
      da0   <= dst_a;
    end
    if (load.s1) begin
      beta1 <= div255(pa0);
      sa1   <= sa0;
      sr1   <= sr0;
      da1   <= da0;
    end
    if (load.s2) begin
      beta2 <= beta1;
      sa2   <= sa1;
      sr2   <= sr1;
      da2   <= da1;
    end
    if (load.s3) begin
      beta3 <= beta2;
      sa3   <= sa2;
      sr3   <= sr2;
      da3   <= da2;
    end
    if (load.s4) begin
      out_a <= alpha_next;
    end
  end

  pbl_lane u_lane_r (
    .clk        (clk),
    .load       (load),
    .src        (src_r),
    .dst        (dst_r),
    .luma       (luma0),
    .saturation (saturation_level),
    .tone       (tone_red),
    .beta       (beta2),
    .mode       (blend_mode),
    .dst_zero   (dst_zero),
    .result     (out_r)
  );

  pbl_lane u_lane_g (
    .clk        (clk),
    .load       (load),
    .src        (src_g),
    .dst        (dst_g),
    .luma       (luma0),
    .saturation (saturation_level),
    .tone       (tone_green),
    .beta       (beta2),
    .mode       (blend_mode),
    .dst_zero   (dst_zero),
    .result     (out_g)
  );

  pbl_lane u_lane_b (
    .clk        (clk),
    .load       (load),
    .src        (src_b),
    .dst        (dst_b),
    .luma       (luma0),
    .saturation (saturation_level),
    .tone       (tone_blue),
    .beta       (beta2),
    .mode       (blend_mode),
    .dst_zero   (dst_zero),
    .result     (out_b)
  );

endmodule

FILE: rtl/pbl_checker.sv
// Port-level checks for the pixel tone-and-blend pipeline, bound to the top level.
`timescale 1ns / 1ps

module pbl_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_r,
  input logic [7:0] out_g,
  input logic [7:0] out_b,
  input logic [7:0] out_a,
  input logic       cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_r) && $stable(out_g)
                               && $stable(out_b) && $stable(out_a))
    else $error("stalled output word changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && cfg_ready)
    else $error("pipeline not empty after reset");

endmodule

bind pixel_tone_and_blend pbl_checker u_pbl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_r     (out_r),
  .out_g     (out_g),
  .out_b     (out_b),
  .out_a     (out_a),
  .cfg_ready (cfg_ready)
);

FILE: tb/pixel_tone_and_blend_tb.sv
// Self-checking testbench for pixel_tone_and_blend: config phases, random pixels, stalls.
`timescale 1ns / 1ps

module pixel_tone_and_blend_tb;
  import pbl_pkg::*;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  class pixel_ledger;
    logic [7:0] global_alpha;
    logic [2:0] mode;
    logic [7:0] saturation;
    logic signed [8:0] tone[3];
    rgba_t pending_pixels[$];
    int errors;

    function new();
      global_alpha = 8'd255;
      mode = MODE_ALPHA;
      saturation = 8'd255;
      tone = '{9'sd0, 9'sd0, 9'sd0};
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [8:0] data);
      case (idx)
        CFG_GLOBAL_ALPHA: global_alpha = data[7:0];
        CFG_BLEND_MODE: mode = data[2:0];
        CFG_SATURATION: saturation = data[7:0];
        CFG_TONE_RED: tone[0] = data;
        CFG_TONE_GREEN: tone[1] = data;
        CFG_TONE_BLUE: tone[2] = data;
        default: ;
      endcase
    endfunction

    // (s*w + d*(255-w)) / 255, truncated
    function int unsigned mix(int unsigned s, int unsigned d, int unsigned w);
      return (s * w + d * (255 - w)) / 255;
    endfunction

    function int unsigned shade(int unsigned c, logic signed [8:0] t);
      int mag;
      mag = t;
      if (mag == 0) return c;
      if (mag < 0) return mix(0, c, (mag < -255) ? 255 : -mag);
      return mix(255, c, mag);
    endfunction

    function rgba_t blend_pixel(rgba_t s, rgba_t d);
      int unsigned c[3];
      int unsigned dc[3];
      int unsigned o[3];
      int unsigned luma, beta, w;
      rgba_t res;
      res = d;
      if (mode == MODE_MASK) begin
        res.a = s.r;
        return res;
      end
      if (mode > MODE_SUB) return res;
      c = '{s.r, s.g, s.b};
      dc = '{d.r, d.g, d.b};
      if (saturation < 8'd255) begin
        luma = (6969 * c[0] + 23434 * c[1] + 2365 * c[2]) / 32768;
        foreach (c[i]) c[i] = mix(c[i], luma, saturation);
      end
      foreach (c[i]) c[i] = shade(c[i], tone[i]);
      beta = (int'(s.a) * int'(global_alpha)) / 255;
      if (mode == MODE_COPY) begin
        o = c;
        res.a = s.a;
      end else if (d.a == 8'd0) begin
        foreach (c[i]) begin
          case (mode)
            MODE_ALPHA: o[i] = c[i];
            MODE_ADD: o[i] = (c[i] + dc[i] > 255) ? 255 : c[i] + dc[i];
            default: o[i] = (dc[i] > c[i]) ? dc[i] - c[i] : 0;
          endcase
        end
        res.a = 8'(beta);
      end else begin
        res.a = (d.a < beta) ? 8'(beta) : d.a;
        foreach (c[i]) begin
          w = (c[i] * beta) / 255;
          case (mode)
            MODE_ALPHA: o[i] = mix(c[i], dc[i], beta);
            MODE_ADD: o[i] = (dc[i] + w > 255) ? 255 : dc[i] + w;
            default: o[i] = (dc[i] > w) ? dc[i] - w : 0;
          endcase
        end
      end
      res.r = 8'(o[0]);
      res.g = 8'(o[1]);
      res.b = 8'(o[2]);
      return res;
    endfunction

    function void accept_pixel(rgba_t s, rgba_t d);
      pending_pixels.push_back(blend_pixel(s, d));
    endfunction

    function void same(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(rgba_t got);
      rgba_t want;
      if (pending_pixels.size() == 0) begin
        $error("output word with no pixel pending: %h", got);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      same("out_r", want.r, got.r);
      same("out_g", want.g, got.g);
      same("out_b", want.b, got.b);
      same("out_a", want.a, got.a);
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] src_r = 8'd0, src_g = 8'd0, src_b = 8'd0, src_a = 8'd0;
  logic [7:0] dst_r = 8'd0, dst_g = 8'd0, dst_b = 8'd0, dst_a = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_r, out_g, out_b, out_a;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = CFG_GLOBAL_ALPHA;
  logic [8:0] cfg_data = 9'd0;

  logic [8:0] reg_val[CFG_TONE_BLUE + 1];
  bit quiet = 1'b0;
  pixel_ledger ledger = new();

  pixel_tone_and_blend uut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) ledger.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        ledger.accept_pixel({src_r, src_g, src_b, src_a}, {dst_r, dst_g, dst_b, dst_a});
      if (out_valid && !out_stall) ledger.check_pixel({out_r, out_g, out_b, out_a});
    end
  end

  initial begin
    forever begin
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!quiet) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [8:0] rand_tone();
    case ($urandom_range(0, 7))
      0: return 9'h0FF;
      1: return 9'h101;
      2: return 9'h100;
      3: return 9'h000;
      default: return 9'($urandom);
    endcase
  endfunction

  task automatic write_regs();
    for (int i = 0; i <= CFG_TONE_BLUE; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= reg_val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(rgba_t s, rgba_t d);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {src_r, src_g, src_b, src_a} <= s;
    {dst_r, dst_g, dst_b, dst_a} <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    @(posedge clk);
    while (ledger.pending_pixels.size() != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int phase_len;
    int r;
    bit first;
    rgba_t s, d;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every mode code, extreme tones and alphas, dst alpha zero and nonzero
    for (int m = 0; m < 8; m++) begin
      reg_val[CFG_BLEND_MODE] = 9'(m);
      reg_val[CFG_GLOBAL_ALPHA] = (m == MODE_SUB) ? 9'd200 : (m[0] ? 9'd255 : 9'd0);
      reg_val[CFG_SATURATION] = m[1] ? 9'd0 : 9'd255;
      reg_val[CFG_TONE_RED] = m[0] ? 9'h0FF : 9'h100;
      reg_val[CFG_TONE_GREEN] = m[1] ? 9'h101 : 9'h000;
      reg_val[CFG_TONE_BLUE] = m[2] ? 9'h0FF : 9'h100;
      write_regs();
      send_pixel(32'h0000_0000, 32'hFFFF_FFFF);
      send_pixel(32'hFFFF_FFFF, 32'h0000_0000);
      send_pixel({8'd200, 8'd17, 8'd90, 8'd128}, {8'd60, 8'd240, 8'd5, 8'd1});
      in_valid <= 1'b0;
      drain();
    end

    sent = 0;
    first = 1'b1;
    while (sent < 1250) begin
      r = $urandom_range(0, 15);
      reg_val[CFG_BLEND_MODE] = (r < 14) ? 9'(r % 5) : 9'($urandom_range(MODE_SUB + 1, 7));
      reg_val[CFG_GLOBAL_ALPHA] = {1'b0, rand_byte()};
      case ($urandom_range(0, 5))
        0: reg_val[CFG_SATURATION] = 9'd0;
        1: reg_val[CFG_SATURATION] = 9'd254;
        2, 3: reg_val[CFG_SATURATION] = 9'd255;
        default: reg_val[CFG_SATURATION] = 9'($urandom_range(0, 255));
      endcase
      reg_val[CFG_TONE_RED] = rand_tone();
      reg_val[CFG_TONE_GREEN] = rand_tone();
      reg_val[CFG_TONE_BLUE] = rand_tone();
      write_regs();
      phase_len = $urandom_range(20, 90);
      for (int k = 0; k < phase_len; k++) begin
        if (sent >= 1100) quiet = 1'b1;
        if (first && k == phase_len / 2) begin
          in_valid <= 1'b0;
          drain();
        end
        s = {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
        d = {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
        if ($urandom_range(0, 4) == 0) d.a = 8'd0;
        send_pixel(s, d);
        sent++;
      end
      in_valid <= 1'b0;
      drain();
      first = 1'b0;
    end

    repeat (20) @(posedge clk);
    if (ledger.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/pbl_pkg.sv
rtl/pbl_lane.sv
rtl/pixel_tone_and_blend.sv
rtl/pbl_checker.sv
tb/pixel_tone_and_blend_tb.sv
